FILE: rtl/core/ksat_pkg.sv
// Package for the keyed sum accumulator table: field widths, status codes and the entry type.
package ksat_pkg;

    localparam int CLIENT_W      = 14;
    localparam int SELLER_W      = 4;
    localparam int AMOUNT_W      = 32;
    localparam int TOTAL_W       = 40;
    localparam int STATUS_W      = 2;
    localparam int INDEX_W       = 6;
    localparam int COUNT_W       = 7;
    localparam int TABLE_ENTRIES = 64;

    localparam logic [SELLER_W-1:0] SELLER_LOW  = SELLER_W'(1);
    localparam logic [SELLER_W-1:0] SELLER_HIGH = SELLER_W'(10);

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_AMT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SELLER = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

    typedef struct packed {
        logic [CLIENT_W-1:0] client;
        logic [SELLER_W-1:0] seller;
        logic [TOTAL_W-1:0]  total;
    } entry_t;

endpackage

FILE: rtl/core/keyed_sum_accumulator_table.sv
// Keyed sum accumulator table: group-by-sum of sales keyed by client and seller.
//
// A transaction is taken when start is high and busy is low. A sale with a zero
// amount or a seller outside 1 to 10 is answered on done in the next cycle. A valid
// sale searches the table in insertion order with one memory read per cycle, stops at
// the first hit or after the last entry in use, and holds busy while it searches;
// done is registered and rises as busy drops. The first sale into an empty table
// needs no search and is answered like a rejected sale. The one read port of the entry
// memory sets the pace of the search. done is high for exactly one cycle and the result
// ports are valid only then; the receiver cannot stall, so results must be taken
// when shown. busy drops together with done, and a new sale may start in that cycle.
module keyed_sum_accumulator_table #(
    parameter int TABLE_ENTRIES = ksat_pkg::TABLE_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ksat_pkg::CLIENT_W-1:0]  client_code,
    input  logic [ksat_pkg::SELLER_W-1:0]  seller_number,
    input  logic [ksat_pkg::AMOUNT_W-1:0]  amount_cents,
    output logic                           done,
    output logic [ksat_pkg::STATUS_W-1:0]  status,
    output logic [ksat_pkg::INDEX_W-1:0]   entry_index,
    output logic                           new_entry,
    output logic [ksat_pkg::TOTAL_W-1:0]   entry_total,
    output logic [ksat_pkg::COUNT_W-1:0]   entry_count
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic state_reg, state_next;
    logic [IDX_W-1:0] chk_reg, chk_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ksat_pkg::CLIENT_W-1:0] client_reg, client_next;
    logic [ksat_pkg::SELLER_W-1:0] seller_reg, seller_next;
    logic [ksat_pkg::AMOUNT_W-1:0] amount_reg, amount_next;

    logic done_reg, done_next;
    logic [ksat_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic new_reg, new_next;
    logic [ksat_pkg::TOTAL_W-1:0] total_reg, total_next;

    ksat_pkg::entry_t mem [TABLE_ENTRIES];
    ksat_pkg::entry_t rd_data_reg;
    ksat_pkg::entry_t wdata;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
    logic we;

    logic hit;
    logic last;
    logic full;
    logic [ksat_pkg::TOTAL_W:0] sum_wide;
    logic [ksat_pkg::TOTAL_W-1:0] sum_sat;
    logic [IDX_W+5:0] index_ext;
    logic [CNT_W+6:0] count_ext;

    assign hit  = (rd_data_reg.client == client_reg) && (rd_data_reg.seller == seller_reg);
    assign last = ((CNT_W'(chk_reg) + CNT_W'(1)) == count_reg);
    assign full = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign sum_wide = {1'b0, rd_data_reg.total}
                    + (ksat_pkg::TOTAL_W + 1)'(amount_reg);
    assign sum_sat = sum_wide[ksat_pkg::TOTAL_W] ? {ksat_pkg::TOTAL_W{1'b1}}
                                                 : sum_wide[ksat_pkg::TOTAL_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        chk_next    = chk_reg;
        count_next  = count_reg;
        client_next = client_reg;
        seller_next = seller_reg;
        amount_next = amount_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        index_next  = index_reg;
        new_next    = new_reg;
        total_next  = total_reg;
        raddr       = '0;
        waddr       = count_reg[IDX_W-1:0];
        we          = 1'b0;
        wdata.client = client_reg;
        wdata.seller = seller_reg;
        wdata.total  = ksat_pkg::TOTAL_W'(amount_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    client_next = client_code;
                    seller_next = seller_number;
                    amount_next = amount_cents;
                    if (amount_cents == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = ksat_pkg::ST_ZERO_AMT;
                        index_next  = '0;
                        new_next    = 1'b0;
                        total_next  = '0;
                    end
                    else if (!(seller_number inside
                               {[ksat_pkg::SELLER_LOW:ksat_pkg::SELLER_HIGH]}))
                    begin
                        done_next   = 1'b1;
                        status_next = ksat_pkg::ST_BAD_SELLER;
                        index_next  = '0;
                        new_next    = 1'b0;
                        total_next  = '0;
                    end
                    else if (count_reg == '0)
                    begin
                        // empty table: append straight away
                        we           = 1'b1;
                        waddr        = '0;
                        wdata.client = client_code;
                        wdata.seller = seller_number;
                        wdata.total  = ksat_pkg::TOTAL_W'(amount_cents);
                        count_next   = CNT_W'(1);
                        done_next    = 1'b1;
                        status_next  = ksat_pkg::ST_OK;
                        index_next   = '0;
                        new_next     = 1'b1;
                        total_next   = ksat_pkg::TOTAL_W'(amount_cents);
                    end
                    else
                    begin
                        raddr      = '0;
                        chk_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    we          = 1'b1;
                    waddr       = chk_reg;
                    wdata.total = sum_sat;
                    done_next   = 1'b1;
                    status_next = ksat_pkg::ST_OK;
                    index_next  = chk_reg;
                    new_next    = 1'b0;
                    total_next  = sum_sat;
                    state_next  = S_IDLE;
                end
                else if (last)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (full)
                    begin
                        status_next = ksat_pkg::ST_FULL;
                        index_next  = '0;
                        new_next    = 1'b0;
                        total_next  = '0;
                    end
                    else
                    begin
                        we          = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                        status_next = ksat_pkg::ST_OK;
                        index_next  = count_reg[IDX_W-1:0];
                        new_next    = 1'b1;
                        total_next  = ksat_pkg::TOTAL_W'(amount_reg);
                    end
                end
                else
                begin
                    raddr    = chk_reg + IDX_W'(1);
                    chk_next = chk_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg    <= chk_next;
        client_reg <= client_next;
        seller_reg <= seller_next;
        amount_reg <= amount_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        new_reg    <= new_next;
        total_reg  <= total_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign index_ext = {6'b0, index_reg};
    assign count_ext = {7'b0, count_reg};

    assign busy        = (state_reg == S_SCAN);
    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_index = index_ext[5:0];
    assign new_entry   = new_reg;
    assign entry_total = total_reg;
    assign entry_count = count_ext[6:0];

    // a result always closes the transaction
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> state_reg == S_IDLE)
        else $error("result shown while still searching");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && new_reg) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append without count increment");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ksat_pkg::ST_OK) |->
        (!new_reg && total_reg == '0 && count_reg == $past(count_reg)))
        else $error("rejected sale changed the table");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> done_reg)
        else $error("count changed outside a result");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the keyed sum accumulator table: directed and random sales.
module testbench;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [ksat_pkg::CLIENT_W-1:0] client;
        logic [ksat_pkg::SELLER_W-1:0] seller;
        logic [ksat_pkg::AMOUNT_W-1:0] amount;
    } sale_t;

    typedef struct packed {
        logic [ksat_pkg::STATUS_W-1:0] status;
        logic [ksat_pkg::INDEX_W-1:0]  index;
        logic                          fresh;
        logic [ksat_pkg::TOTAL_W-1:0]  total;
        logic [ksat_pkg::COUNT_W-1:0]  count;
    } booking_t;

    typedef struct packed {
        logic [ksat_pkg::CLIENT_W-1:0] client;
        logic [ksat_pkg::SELLER_W-1:0] seller;
    } key_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [ksat_pkg::CLIENT_W-1:0] client_code = '0;
    logic [ksat_pkg::SELLER_W-1:0] seller_number = '0;
    logic [ksat_pkg::AMOUNT_W-1:0] amount_cents = '0;
    logic                          done;
    logic [ksat_pkg::STATUS_W-1:0] status;
    logic [ksat_pkg::INDEX_W-1:0]  entry_index;
    logic                          new_entry;
    logic [ksat_pkg::TOTAL_W-1:0]  entry_total;
    logic [ksat_pkg::COUNT_W-1:0]  entry_count;

    // shadow of the sales ledger
    logic [ksat_pkg::CLIENT_W-1:0] ledger_client [ksat_pkg::TABLE_ENTRIES];
    logic [ksat_pkg::SELLER_W-1:0] ledger_seller [ksat_pkg::TABLE_ENTRIES];
    logic [ksat_pkg::TOTAL_W-1:0]  ledger_total [ksat_pkg::TABLE_ENTRIES];
    int                            ledger_used = 0;

    sale_t    sale_queue [$];
    booking_t booking_due [$];
    key_t     plan_keys [$];

    sale_t    offered;
    booking_t want;
    booking_t got;
    int       plan_total = 0;
    int       sales_taken = 0;
    int       hold_pct;
    int       results_seen = 0;
    int       fault_count = 0;
    int       quiet_cycles = 0;
    int       status_seen [4] = '{0, 0, 0, 0};
    int       saturated_seen = 0;
    int       peak_count = 0;

    keyed_sum_accumulator_table i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .client_code   (client_code),
        .seller_number (seller_number),
        .amount_cents  (amount_cents),
        .done          (done),
        .status        (status),
        .entry_index   (entry_index),
        .new_entry     (new_entry),
        .entry_total   (entry_total),
        .entry_count   (entry_count)
    );

    always #2 clk = ~clk;

    function automatic booking_t book_sale(sale_t s);
        booking_t                   r;
        logic [ksat_pkg::TOTAL_W:0] sum;
        int                         hit;
        r = '0;
        r.status = ksat_pkg::ST_OK;
        r.count = ksat_pkg::COUNT_W'(ledger_used);
        if (s.amount == '0)
        begin
            r.status = ksat_pkg::ST_ZERO_AMT;
        end
        else if (s.seller < ksat_pkg::SELLER_LOW || s.seller > ksat_pkg::SELLER_HIGH)
        begin
            r.status = ksat_pkg::ST_BAD_SELLER;
        end
        else
        begin
            hit = -1;
            for (int i = 0; i < ledger_used; i++)
            begin
                if (hit < 0 && ledger_client[i] == s.client && ledger_seller[i] == s.seller)
                    hit = i;
            end
            if (hit >= 0)
            begin
                sum = ledger_total[hit] + s.amount;
                ledger_total[hit] = sum[ksat_pkg::TOTAL_W] ? '1 : sum[ksat_pkg::TOTAL_W-1:0];
                r.index = ksat_pkg::INDEX_W'(hit);
                r.total = ledger_total[hit];
            end
            else if (ledger_used >= ksat_pkg::TABLE_ENTRIES)
            begin
                r.status = ksat_pkg::ST_FULL;
            end
            else
            begin
                ledger_client[ledger_used] = s.client;
                ledger_seller[ledger_used] = s.seller;
                ledger_total[ledger_used] = ksat_pkg::TOTAL_W'(s.amount);
                r.index = ksat_pkg::INDEX_W'(ledger_used);
                r.fresh = 1'b1;
                r.total = ksat_pkg::TOTAL_W'(s.amount);
                ledger_used++;
                r.count = ksat_pkg::COUNT_W'(ledger_used);
            end
        end
        return r;
    endfunction

    function automatic void queue_sale(logic [ksat_pkg::CLIENT_W-1:0] c,
                                       logic [ksat_pkg::SELLER_W-1:0] sl,
                                       logic [ksat_pkg::AMOUNT_W-1:0] a);
        sale_t s;
        key_t  k;
        bit    known;
        s.client = c;
        s.seller = sl;
        s.amount = a;
        k.client = c;
        k.seller = sl;
        sale_queue.push_back(s);
        if (a != '0 && sl >= ksat_pkg::SELLER_LOW && sl <= ksat_pkg::SELLER_HIGH)
        begin
            known = 1'b0;
            foreach (plan_keys[i])
            begin
                if (plan_keys[i] == k)
                    known = 1'b1;
            end
            if (!known && plan_keys.size() < ksat_pkg::TABLE_ENTRIES)
                plan_keys.push_back(k);
        end
    endfunction

    function automatic logic [ksat_pkg::AMOUNT_W-1:0] pick_amount();
        case ($urandom_range(3))
            0: return ksat_pkg::AMOUNT_W'($urandom_range(1, 999));
            1: return ksat_pkg::AMOUNT_W'(1) << $urandom_range(ksat_pkg::AMOUNT_W - 1);
            2: return '1;
            default: return ksat_pkg::AMOUNT_W'($urandom);
        endcase
    endfunction

    function automatic logic [ksat_pkg::SELLER_W-1:0] pick_bad_seller();
        if ($urandom_range(5) == 0)
            return '0;
        return ksat_pkg::SELLER_HIGH + ksat_pkg::SELLER_W'($urandom_range(1, 5));
    endfunction

    // mixed traffic; with fill set, new keys are forced so the table is full by the end
    function automatic void plan_mix(int n, int fresh_pct, bit fill);
        int   r;
        key_t k;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < fresh_pct
                || (fill && n - i <= ksat_pkg::TABLE_ENTRIES - plan_keys.size()))
            begin
                queue_sale(ksat_pkg::CLIENT_W'($urandom_range(16383)),
                           ksat_pkg::SELLER_W'($urandom_range(ksat_pkg::SELLER_LOW,
                                                              ksat_pkg::SELLER_HIGH)),
                           pick_amount() | ksat_pkg::AMOUNT_W'(fill));
            end
            else if (r < fresh_pct + 40)
            begin
                k = plan_keys[$urandom_range(plan_keys.size() - 1)];
                queue_sale(k.client, k.seller, pick_amount());
            end
            else if (r < fresh_pct + 52)
            begin
                queue_sale(ksat_pkg::CLIENT_W'($urandom_range(16383)),
                           ksat_pkg::SELLER_W'($urandom_range(15)), '0);
            end
            else if (r < fresh_pct + 64)
            begin
                queue_sale(ksat_pkg::CLIENT_W'($urandom_range(16383)), pick_bad_seller(),
                           pick_amount());
            end
            else
            begin
                queue_sale(ksat_pkg::CLIENT_W'($urandom_range(16383)),
                           ksat_pkg::SELLER_W'($urandom_range(15)),
                           ksat_pkg::AMOUNT_W'($urandom));
            end
        end
    endfunction

    function automatic void log_fault(string what, booking_t w, booking_t g);
        fault_count++;
        if (fault_count <= REPORT_MAX)
        begin
            $display({"ERROR %s: status %0d/%0d index %0d/%0d new %0d/%0d",
                      " total %0d/%0d count %0d/%0d"},
                     what, w.status, g.status, w.index, g.index, w.fresh, g.fresh,
                     w.total, g.total, w.count, g.count);
        end
    endfunction

    // driver: hold a transaction until accepted, idle between transactions per phase
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                booking_due.push_back(book_sale(offered));
                sales_taken++;
            end
            hold_pct = (sales_taken < plan_total / 3) ? 15 :
                       (sales_taken < 2 * plan_total / 3) ? 86 : 0;
            if (!(start && busy))
            begin
                if (sale_queue.size() != 0 && $urandom_range(99) >= hold_pct)
                begin
                    offered = sale_queue.pop_front();
                    start <= 1'b1;
                    client_code <= offered.client;
                    seller_number <= offered.seller;
                    amount_cents <= offered.amount;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got = {status, entry_index, new_entry, entry_total, entry_count};
            if (booking_due.size() == 0)
            begin
                log_fault("unexpected result", '0, got);
            end
            else
            begin
                want = booking_due.pop_front();
                if (got !== want)
                    log_fault("mismatch (exp/act)", want, got);
                results_seen++;
                status_seen[want.status]++;
                if (want.status == ksat_pkg::ST_OK && want.total == '1)
                    saturated_seen++;
                if (int'(want.count) > peak_count)
                    peak_count = int'(want.count);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        key_t sat_key;

        // directed
        queue_sale(14'd0, 4'd1, 32'd1);
        queue_sale(14'd16383, 4'd10, 32'hFFFF_FFFF);
        queue_sale(14'd0, 4'd1, 32'd0);
        queue_sale(14'd5, 4'd0, 32'd100);
        queue_sale(14'd5, 4'd11, 32'd100);
        queue_sale(14'd5, 4'd15, 32'hFFFF_FFFF);
        queue_sale(14'd7, 4'd0, 32'd0);
        queue_sale(14'd7, 4'd15, 32'd0);
        queue_sale(14'd0, 4'd1, 32'd1);
        queue_sale(14'd0, 4'd2, 32'd250);
        queue_sale(14'd1, 4'd1, 32'd250);
        queue_sale(14'd16383, 4'd10, 32'hFFFF_FFFF);
        queue_sale(14'd9999, 4'd5, 32'h8000_0000);
        queue_sale(14'h2AAA, 4'd7, 32'h5555_5555);
        queue_sale(14'h1555, 4'd8, 32'hAAAA_AAAA);
        queue_sale(14'h1555, 4'd8, 32'h0000_0001);
        queue_sale(14'd9999, 4'd5, 32'h8000_0000);
        queue_sale(14'd16383, 4'd9, 32'd0);

        // mixed traffic until the table is full
        plan_mix(250, 25, 1'b1);

        // drive one low-index entry into saturation
        sat_key = plan_keys[$urandom_range(3)];
        for (int i = 0; i < 290; i++)
        begin
            if ($urandom_range(99) < 92)
                queue_sale(sat_key.client, sat_key.seller,
                           32'hFFFF_0000 | ksat_pkg::AMOUNT_W'($urandom_range(65535)));
            else
                queue_sale(ksat_pkg::CLIENT_W'($urandom_range(16383)), pick_bad_seller(),
                           pick_amount());
        end

        // full table: hits keep accumulating, new keys are refused
        plan_mix(200, 20, 1'b0);
        plan_total = sale_queue.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (sale_queue.size() != 0 || start || booking_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (booking_due.size() != 0)
            log_fault("missing result", booking_due[0], '0);

        $display({"%0d sales checked: %0d stored, %0d zero amount, %0d bad seller,",
                  " %0d table full"},
                 results_seen, status_seen[ksat_pkg::ST_OK], status_seen[ksat_pkg::ST_ZERO_AMT],
                 status_seen[ksat_pkg::ST_BAD_SELLER], status_seen[ksat_pkg::ST_FULL]);
        $display("Peak entry count %0d, %0d updates at the saturated total, %0d faults",
                 peak_count, saturated_seen, fault_count);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
